[sv/cps_pkg.sv]
// ----------------------------------------------------------------------------
// cps_pkg: shared codes for the closest point on segment unit
// clamp codes reported with each result beat
// ----------------------------------------------------------------------------
`default_nettype none

package cps_pkg;

  // clamp code values
  localparam logic [1:0] CODE_INTERIOR = 2'd0;
  localparam logic [1:0] CODE_START    = 2'd1;
  localparam logic [1:0] CODE_END      = 2'd2;

endpackage

`default_nettype wire

[sv/cps_div_stage.sv]
// ----------------------------------------------------------------------------
// cps_div_stage: one radix-2 step of the projection divide
// folds one bit of |v| into v*s/L for all three axes, registered
// ----------------------------------------------------------------------------
`default_nettype none

module cps_div_stage #(
  parameter int VW   = 33,
  parameter int LW   = 66,
  parameter int SW   = 197,
  parameter int STEP = 0
) (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire logic                   en,
  input  wire logic                   in_vld,
  input  wire logic [2:0][VW-1:0]     in_mag,
  input  wire logic [LW-1:0]          in_s,
  input  wire logic [LW-1:0]          in_l,
  input  wire logic [2:0][LW-1:0]     in_rem,
  input  wire logic [2:0][VW-1:0]     in_q,
  input  wire logic [SW-1:0]          in_side,
  output logic                        out_vld,
  output logic [2:0][VW-1:0]          out_mag,
  output logic [LW-1:0]               out_s,
  output logic [LW-1:0]               out_l,
  output logic [2:0][LW-1:0]          out_rem,
  output logic [2:0][VW-1:0]          out_q,
  output logic [SW-1:0]               out_side
);

  localparam int BI = VW - 1 - STEP;

  logic                    vld_r;
  logic [2:0][VW-1:0]      mag_r;
  logic [LW-1:0]           s_r;
  logic [LW-1:0]           l_r;
  logic [2:0][LW-1:0]      rem_r, rem_nxt;
  logic [2:0][VW-1:0]      q_r, q_nxt;
  logic [SW-1:0]           side_r;

  // remainder step: 2*rem + bit*s, then take off 0, L or 2L
  always_comb begin
    logic [LW+1:0] tmp;
    logic [LW+1:0] l1;
    logic [LW+1:0] l2;
    l1 = {2'b00, in_l};
    l2 = {1'b0, in_l, 1'b0};
    for (int i = 0; i < 3; i++) begin
      tmp = {1'b0, in_rem[i], 1'b0} + (in_mag[i][BI] ? {2'b00, in_s} : '0);
      if (tmp >= l2) begin
        rem_nxt[i] = LW'(tmp - l2);
        q_nxt[i]   = {in_q[i][VW-2:0], 1'b0} + VW'(2);
      end else if (tmp >= l1) begin
        rem_nxt[i] = LW'(tmp - l1);
        q_nxt[i]   = {in_q[i][VW-2:0], 1'b1};
      end else begin
        rem_nxt[i] = LW'(tmp);
        q_nxt[i]   = {in_q[i][VW-2:0], 1'b0};
      end
    end
  end

  // valid bit
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (en) begin
      vld_r <= in_vld;
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (en) begin
      mag_r  <= in_mag;
      s_r    <= in_s;
      l_r    <= in_l;
      rem_r  <= rem_nxt;
      q_r    <= q_nxt;
      side_r <= in_side;
    end
  end

  assign out_vld  = vld_r;
  assign out_mag  = mag_r;
  assign out_s    = s_r;
  assign out_l    = l_r;
  assign out_rem  = rem_r;
  assign out_q    = q_r;
  assign out_side = side_r;

endmodule

`default_nettype wire

[sv/closest_point_on_segment_unit.sv]
// ----------------------------------------------------------------------------
// closest_point_on_segment_unit: nearest point on segment AB to point P
// registered stages: differences, products, dot products, classify, divide, output
// throughput one beat per cycle while the output is not stalled; the divide is one
// registered step per bit of |B-A|, so depth grows with COORD_BITS
// a stall on the output freezes the whole pipeline, nothing dropped
// synchronous active-low reset clears the valid bits only
// ----------------------------------------------------------------------------
`default_nettype none

module closest_point_on_segment_unit #(
  parameter int COORD_BITS = 32
) (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         in_valid,
  output logic                              in_ready,
  input  wire logic signed [COORD_BITS-1:0] in_a_x,
  input  wire logic signed [COORD_BITS-1:0] in_a_y,
  input  wire logic signed [COORD_BITS-1:0] in_a_z,
  input  wire logic signed [COORD_BITS-1:0] in_b_x,
  input  wire logic signed [COORD_BITS-1:0] in_b_y,
  input  wire logic signed [COORD_BITS-1:0] in_b_z,
  input  wire logic signed [COORD_BITS-1:0] in_p_x,
  input  wire logic signed [COORD_BITS-1:0] in_p_y,
  input  wire logic signed [COORD_BITS-1:0] in_p_z,
  output logic                              out_valid,
  input  wire logic                         out_ready,
  output logic signed [COORD_BITS-1:0]      out_near_x,
  output logic signed [COORD_BITS-1:0]      out_near_y,
  output logic signed [COORD_BITS-1:0]      out_near_z,
  output logic [1:0]                        out_clamp_code
);

  localparam int CB = COORD_BITS;
  localparam int VW = CB + 1;       // difference width
  localparam int PW = 2 * VW;       // product width
  localparam int LW = PW;           // dot product magnitude width
  localparam int SW = 6 * CB + 5;   // a, b, sign of v, clamp code

  logic en;

  // ---------------- stage 1: differences
  logic                        vld1_r;
  logic signed [2:0][VW-1:0]   v1_r, c1_r;
  logic [2:0][CB-1:0]          a1_r, b1_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld1_r <= 1'b0;
    end else if (en) begin
      vld1_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      v1_r[0] <= {in_b_x[CB-1], in_b_x} - {in_a_x[CB-1], in_a_x};
      v1_r[1] <= {in_b_y[CB-1], in_b_y} - {in_a_y[CB-1], in_a_y};
      v1_r[2] <= {in_b_z[CB-1], in_b_z} - {in_a_z[CB-1], in_a_z};
      c1_r[0] <= {in_p_x[CB-1], in_p_x} - {in_a_x[CB-1], in_a_x};
      c1_r[1] <= {in_p_y[CB-1], in_p_y} - {in_a_y[CB-1], in_a_y};
      c1_r[2] <= {in_p_z[CB-1], in_p_z} - {in_a_z[CB-1], in_a_z};
      a1_r    <= {in_a_z, in_a_y, in_a_x};
      b1_r    <= {in_b_z, in_b_y, in_b_x};
    end
  end

  // ---------------- stage 2: products and magnitudes
  logic                        vld2_r;
  logic [2:0][PW-1:0]          pvc2_r, pvv2_r;
  logic [2:0][VW-1:0]          mag2_r;
  logic [2:0]                  neg2_r;
  logic [2:0][CB-1:0]          a2_r, b2_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld2_r <= 1'b0;
    end else if (en) begin
      vld2_r <= vld1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        pvc2_r[i] <= PW'($signed(v1_r[i]) * $signed(c1_r[i]));
        pvv2_r[i] <= PW'($signed(v1_r[i]) * $signed(v1_r[i]));
        mag2_r[i] <= v1_r[i][VW-1] ? VW'(-v1_r[i]) : v1_r[i];
        neg2_r[i] <= v1_r[i][VW-1];
      end
      a2_r <= a1_r;
      b2_r <= b1_r;
    end
  end

  // ---------------- stage 3: dot products
  logic                        vld3_r;
  logic signed [PW+1:0]        s3_r;
  logic [LW-1:0]               l3_r;
  logic [2:0][VW-1:0]          mag3_r;
  logic [2:0]                  neg3_r;
  logic [2:0][CB-1:0]          a3_r, b3_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld3_r <= 1'b0;
    end else if (en) begin
      vld3_r <= vld2_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s3_r   <= {{2{pvc2_r[0][PW-1]}}, pvc2_r[0]} + {{2{pvc2_r[1][PW-1]}}, pvc2_r[1]}
              + {{2{pvc2_r[2][PW-1]}}, pvc2_r[2]};
      l3_r   <= pvv2_r[0] + pvv2_r[1] + pvv2_r[2];
      mag3_r <= mag2_r;
      neg3_r <= neg2_r;
      a3_r   <= a2_r;
      b3_r   <= b2_r;
    end
  end

  // ---------------- stage 4: classify against the segment ends
  logic                        vld4_r;
  logic [LW-1:0]               s4_r, l4_r;
  logic [2:0][VW-1:0]          mag4_r;
  logic [SW-1:0]               side4_r;
  logic [1:0]                  code4_nxt;

  always_comb begin
    if (l3_r == '0 || s3_r[PW+1]) begin
      code4_nxt = cps_pkg::CODE_START;
    end else if (s3_r > $signed({2'b00, l3_r})) begin
      code4_nxt = cps_pkg::CODE_END;
    end else begin
      code4_nxt = cps_pkg::CODE_INTERIOR;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld4_r <= 1'b0;
    end else if (en) begin
      vld4_r <= vld3_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s4_r    <= s3_r[LW-1:0];
      l4_r    <= l3_r;
      mag4_r  <= mag3_r;
      side4_r <= {code4_nxt, neg3_r, b3_r, a3_r};
    end
  end

  // ---------------- divide chain, one quotient step per stage
  logic [VW:0]                   dv_vld;
  logic [VW:0][2:0][VW-1:0]      dv_mag;
  logic [VW:0][LW-1:0]           dv_s, dv_l;
  logic [VW:0][2:0][LW-1:0]      dv_rem;
  logic [VW:0][2:0][VW-1:0]      dv_q;
  logic [VW:0][SW-1:0]           dv_side;

  assign dv_vld[0]  = vld4_r;
  assign dv_mag[0]  = mag4_r;
  assign dv_s[0]    = s4_r;
  assign dv_l[0]    = l4_r;
  assign dv_rem[0]  = '0;
  assign dv_q[0]    = '0;
  assign dv_side[0] = side4_r;

  for (genvar k = 0; k < VW; k++) begin : g_div
    cps_div_stage #(
      .VW(VW), .LW(LW), .SW(SW), .STEP(k)
    ) u_step (
      .clk      (clk),
      .rst_n    (rst_n),
      .en       (en),
      .in_vld   (dv_vld[k]),
      .in_mag   (dv_mag[k]),
      .in_s     (dv_s[k]),
      .in_l     (dv_l[k]),
      .in_rem   (dv_rem[k]),
      .in_q     (dv_q[k]),
      .in_side  (dv_side[k]),
      .out_vld  (dv_vld[k+1]),
      .out_mag  (dv_mag[k+1]),
      .out_s    (dv_s[k+1]),
      .out_l    (dv_l[k+1]),
      .out_rem  (dv_rem[k+1]),
      .out_q    (dv_q[k+1]),
      .out_side (dv_side[k+1])
    );
  end

  // ---------------- output stage: round, apply sign, select
  logic [2:0][CB-1:0]  fa, fb;
  logic [2:0]          fneg;
  logic [1:0]          fcode;
  logic [2:0][CB-1:0]  near_nxt;
  logic                out_vld_r;
  logic [2:0][CB-1:0]  near_r;
  logic [1:0]          code_r;

  assign fa    = dv_side[VW][3*CB-1:0];
  assign fb    = dv_side[VW][6*CB-1:3*CB];
  assign fneg  = dv_side[VW][6*CB+2:6*CB];
  assign fcode = dv_side[VW][6*CB+4:6*CB+3];

  always_comb begin
    logic [VW-1:0] qr;
    logic [VW:0]   qs;
    logic [VW:0]   sum;
    for (int i = 0; i < 3; i++) begin
      qr  = dv_q[VW][i] + VW'({dv_rem[VW][i], 1'b0} >= {1'b0, dv_l[VW]});
      qs  = fneg[i] ? (VW+1)'(-{1'b0, qr}) : {1'b0, qr};
      sum = {{2{fa[i][CB-1]}}, fa[i]} + qs;
      case (fcode)
        cps_pkg::CODE_START: near_nxt[i] = fa[i];
        cps_pkg::CODE_END:   near_nxt[i] = fb[i];
        default:             near_nxt[i] = sum[CB-1:0];
      endcase
    end
  end

  assign en = !out_vld_r || out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (en) begin
      out_vld_r <= dv_vld[VW];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      near_r <= near_nxt;
      code_r <= fcode;
    end
  end

  assign in_ready       = en;
  assign out_valid      = out_vld_r;
  assign out_near_x     = near_r[0];
  assign out_near_y     = near_r[1];
  assign out_near_z     = near_r[2];
  assign out_clamp_code = code_r;

  // ---------------- checks
  a_code_legal: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_clamp_code == cps_pkg::CODE_INTERIOR ||
                   out_clamp_code == cps_pkg::CODE_START ||
                   out_clamp_code == cps_pkg::CODE_END))
    else $error("illegal clamp code");

  a_stall_frees_input: assert property (@(posedge clk) disable iff (!rst_n)
    in_ready == (!out_valid || out_ready))
    else $error("input ready does not follow output stall");

  a_stall_holds_chain: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=> $stable(dv_vld) && out_valid)
    else $error("pipeline moved during stall");

endmodule

`default_nettype wire
